[rtl/scan_nearest_obstacle_repulsion_assert.svh]
// Assertion macros for the nearest-obstacle repulsion block
`ifndef SCAN_NEAREST_OBSTACLE_REPULSION_ASSERT_SVH
`define SCAN_NEAREST_OBSTACLE_REPULSION_ASSERT_SVH
// Property must hold on every clock edge outside reset
`define SNOR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication form
`define SNOR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/snor_pkg.sv]
// ----------------------------------------------------------------------------
// snor_pkg
// Shared types and constants of the nearest-obstacle repulsion block.
// ----------------------------------------------------------------------------
package snor_pkg;

  localparam int unsigned TableLen = 24;
  localparam int unsigned RangeW   = 16;
  localparam int unsigned AngW     = 16;

  localparam logic [1:0] RegAngleStart = 2'd0;
  localparam logic [1:0] RegAngleStep  = 2'd1;
  localparam logic [1:0] RegNearThr    = 2'd2;

  localparam logic signed [33:0] KinvQ30 = 34'sd652032874;

  // Scan summary handed from the front part to the back part
  typedef struct packed {
    logic              near;
    logic [RangeW-1:0] range;
    logic [AngW-1:0]   angle;
  } scan_sum_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
      5'd6: r = 32'd10680862;    5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
      5'd20: r = 32'd652;        5'd21: r = 32'd326;
      5'd22: r = 32'd163;        5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/snor_front.sv]
// ----------------------------------------------------------------------------
// snor_front
// Running minimum over scan samples; emits one scan summary per scan.
// ----------------------------------------------------------------------------
module snor_front import snor_pkg::*; #(
  parameter int unsigned IdxW       = 11,
  parameter int unsigned MaxSamples = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RangeW-1:0] range_sample_i,
  input  logic              last_sample_i,
  input  logic [AngW-1:0]   angle_start_i,
  input  logic [AngW-1:0]   angle_step_i,
  input  logic [RangeW-1:0] near_threshold_i,
  output logic              sum_valid_o,
  input  logic              sum_ready_i,
  output scan_sum_t         sum_o
);

  localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxSamples - 1);

  logic [RangeW-1:0] best_q, best_d, cur_best;
  logic [IdxW-1:0]   bidx_q, bidx_d, cur_idx, sidx_q, sidx_d;
  logic              calc_q;       // angle-multiply step, set once the last sample is taken
  logic [RangeW-1:0] crange_q;
  logic [IdxW-1:0]   cidx_q;
  logic              cnear_q;
  logic [AngW-1:0]   prod;
  logic              take;

  // one scan finishing at a time; stall while summary pending
  assign in_ready_o = !calc_q && !sum_valid_o;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    if (range_sample_i < best_q) begin
      cur_best = range_sample_i;
      cur_idx  = sidx_q;
    end else begin
      cur_best = best_q;
      cur_idx  = bidx_q;
    end
    best_d = best_q;
    bidx_d = bidx_q;
    sidx_d = sidx_q;
    if (take) begin
      if (last_sample_i) begin
        best_d = {RangeW{1'b1}};
        bidx_d = '0;
        sidx_d = '0;
      end else begin
        best_d = cur_best;
        bidx_d = cur_idx;
        sidx_d = (sidx_q == IdxMax) ? sidx_q : sidx_q + 1'b1;
      end
    end
  end

  // angle = start + step * index, wrapping to 16 bits
  assign prod = AngW'(angle_start_i + AngW'(angle_step_i * AngW'(cidx_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= {RangeW{1'b1}};
      bidx_q      <= '0;
      sidx_q      <= '0;
      calc_q      <= 1'b0;
      sum_valid_o <= 1'b0;
    end else begin
      best_q <= best_d;
      bidx_q <= bidx_d;
      sidx_q <= sidx_d;
      calc_q <= take && last_sample_i;
      if (calc_q) sum_valid_o <= 1'b1;
      else if (sum_ready_i) sum_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_sample_i) begin
      crange_q <= cur_best;
      cidx_q   <= cur_idx;
      cnear_q  <= cur_best < near_threshold_i;
    end
    if (calc_q) begin
      sum_o.near  <= cnear_q;
      sum_o.range <= crange_q;
      sum_o.angle <= prod;
    end
  end

endmodule

[rtl/snor_back.sv]
// ----------------------------------------------------------------------------
// snor_back
// Iterative CORDIC and serial divide turn one near scan summary into a vector.
// ----------------------------------------------------------------------------
module snor_back import snor_pkg::*; #(
  parameter int unsigned Steps = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sum_valid_i,
  output logic                     sum_ready_o,
  input  scan_sum_t                sum_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     obstacle_seen_o,
  output logic signed [15:0]       push_x_o,
  output logic signed [15:0]       push_y_o
);

  localparam int unsigned NSteps = (Steps > TableLen) ? TableLen : Steps;
  localparam logic [4:0]  LastStep = 5'(NSteps - 1);
  localparam logic [2:0] StIdle = 3'd0, StRot = 3'd1, StDivX = 3'd2,
                         StDivY = 3'd3, StOut = 3'd4;

  logic [2:0]               st_q;
  logic [4:0]               it_q;
  logic signed [33:0]       x_q, y_q, z_q;
  logic                     flip_q, near_q;
  logic [RangeW-1:0]        rng_q;
  // divider: magnitude / (range*4096), rounded; quotient register 33 bits wide
  logic [5:0]               dcnt_q;
  logic [33:0]              rem_q;
  logic [32:0]              quo_q;
  logic [33:0]              num_q;
  logic                     neg_q, zero_q;
  logic signed [15:0]       px_q, py_q;
  logic [31:0]              a32;
  logic signed [33:0]       dx, dy, at, comp, cx, cy;
  logic [33:0]              mag, den, trial;
  logic [33:0]              rem_sh;
  logic signed [15:0]       sat;
  logic [32:0]              qr;

  assign sum_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign obstacle_seen_o = near_q;
  assign push_x_o = px_q;
  assign push_y_o = py_q;

  assign a32 = {sum_i.angle, 16'h0};
  assign dx  = y_q >>> it_q;
  assign dy  = x_q >>> it_q;
  assign at  = $signed({2'b00, atan_turn(it_q)});
  assign cx  = flip_q ? -x_q : x_q;
  assign cy  = flip_q ? -y_q : y_q;
  assign comp = (st_q == StDivX) ? cx : cy;
  assign mag  = comp[33] ? 34'(-comp) : 34'(comp);
  // numerator is doubled magnitude plus divisor; 33 steps drop its last
  // bit, so the quotient is (mag + d/2) / d, rounding half up
  assign den    = {6'd0, rng_q, 12'd0};
  assign rem_sh = {rem_q[32:0], num_q[33]};
  assign trial  = rem_sh - den;
  assign qr     = {quo_q[31:0], !trial[33]};

  always_comb begin
    if (zero_q) sat = comp[33] ? -16'sd32768 : ((mag == '0) ? 16'sd0 : 16'sd32767);
    else if (quo_q > 33'd32767) sat = neg_q ? -16'sd32768 : 16'sd32767;
    else sat = neg_q ? -$signed(quo_q[15:0]) : $signed(quo_q[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      it_q   <= '0;
      dcnt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (sum_valid_i) begin
          st_q <= sum_i.near ? StRot : StOut;
          it_q <= '0;
        end
        StRot: if (it_q == LastStep) begin
          st_q <= StDivX;
          dcnt_q <= '0;
        end else it_q <= it_q + 5'd1;
        StDivX: if (zero_q || dcnt_q == 6'd34) begin
          st_q <= StDivY;
          dcnt_q <= '0;
        end else dcnt_q <= dcnt_q + 6'd1;
        StDivY: if (zero_q || dcnt_q == 6'd34) st_q <= StOut;
          else dcnt_q <= dcnt_q + 6'd1;
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (sum_valid_i) begin
        logic [31:0] u;
        u = a32;
        flip_q <= (a32 >= 32'h4000_0000) && (a32 < 32'hC000_0000);
        if ((a32 >= 32'h4000_0000) && (a32 < 32'hC000_0000)) u = a32 + 32'h8000_0000;
        z_q    <= 34'($signed(u));
        x_q    <= KinvQ30;
        y_q    <= '0;
        near_q <= sum_i.near;
        rng_q  <= sum_i.range;
        zero_q <= (sum_i.range == '0);
        px_q   <= '0;
        py_q   <= '0;
      end
      StRot: begin
        if (!z_q[33]) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
        end
      end
      StDivX, StDivY: begin
        // zero range saturates at once from the sign of the component
        if (zero_q || dcnt_q == 6'd34) begin
          if (st_q == StDivX) px_q <= sat; else py_q <= sat;
        end else if (dcnt_q == 6'd0) begin
          neg_q <= comp[33];
          num_q <= {mag[32:0], 1'b0} + den;
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= {num_q[32:0], 1'b0};
          rem_q <= trial[33] ? rem_sh : trial;
          quo_q <= qr;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/scan_nearest_obstacle_repulsion.sv]
// Result path: last sample, front-end angle step and summary, CORDIC rotation,
// X and Y divides, output; zero range saturates, no obstacle skips to output.
// Throughput: one sample per cycle; the last sample of a scan stalls input
// while its summary forms and until the back end takes it.
// Reset: asynchronous active low; configuration registers return to 0, 182, 1024.
// ----------------------------------------------------------------------------
// scan_nearest_obstacle_repulsion
// Top level: config registers, minimum-tracking front, vector back end.
// ----------------------------------------------------------------------------
module scan_nearest_obstacle_repulsion import snor_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = 2048,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        range_sample_i,
  input  logic               last_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               obstacle_seen_o,
  output logic signed [15:0] push_x_o,
  output logic signed [15:0] push_y_o
);

  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [15:0] start_q, step_q, thr_q;
  logic        sum_valid, sum_ready;
  scan_sum_t   sum;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'd0;
      step_q  <= 16'd182;
      thr_q   <= 16'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegAngleStart: start_q <= cfg_data_i;
        RegAngleStep:  step_q  <= cfg_data_i;
        RegNearThr:    thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  snor_front #(.IdxW(IdxW), .MaxSamples(MAX_SAMPLES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .range_sample_i, .last_sample_i,
    .angle_start_i(start_q), .angle_step_i(step_q), .near_threshold_i(thr_q),
    .sum_valid_o(sum_valid), .sum_ready_i(sum_ready), .sum_o(sum)
  );

  snor_back #(.Steps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .sum_valid_i(sum_valid), .sum_ready_o(sum_ready), .sum_i(sum),
    .out_valid_o, .out_ready_i, .obstacle_seen_o, .push_x_o, .push_y_o
  );

endmodule

[rtl/snor_checker.sv]
// ----------------------------------------------------------------------------
// snor_checker
// Port-level checks of the repulsion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_nearest_obstacle_repulsion_assert.svh"
module snor_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_sample_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        obstacle_seen_o,
  input logic [15:0] push_x_o,
  input logic [15:0] push_y_o
);
  `SNOR_ASSERT(a_no_obst_zero, !out_valid_o || obstacle_seen_o || (push_x_o == 16'd0 && push_y_o == 16'd0), "no obstacle but nonzero vector")
  `SNOR_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(push_x_o) && $stable(push_y_o), "result dropped")
  `SNOR_ASSERT_IMP(a_last_stall, in_valid_i && in_ready_o && last_sample_i, !in_ready_o, "accepted after last sample")
endmodule

bind scan_nearest_obstacle_repulsion snor_checker u_snor_checker (.*);

[test/scan_nearest_obstacle_repulsion_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_nearest_obstacle_repulsion_tb
// Sends laser scans into the repulsion block and checks every result against
// an in-bench predictor of the running minimum, CORDIC and Q8.8 conversion.
// ----------------------------------------------------------------------------
module scan_nearest_obstacle_repulsion_tb;
  import snor_pkg::*;

  localparam int MaxSamples = 2048;
  localparam int CordicSteps = 16;
  localparam int CycleLimit = 4000000;
  localparam logic [1:0] RegBeyond = 2'd3;

  typedef struct {
    logic        near;
    logic [15:0] px;
    logic [15:0] py;
  } push_t;

  // Scoreboard: predicts scan results and checks them in order
  class repulsion_board;
    logic [15:0] ang_start, ang_step, near_thr;
    logic [15:0] min_range;
    int          min_idx, idx;
    push_t       pending[$];
    int          errors;

    function new();
      ang_start = 16'd0; ang_step = 16'd182; near_thr = 16'd1024;
      min_range = 16'hFFFF; min_idx = 0; idx = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] a, logic [15:0] d);
      if (a == RegAngleStart) ang_start = d;
      else if (a == RegAngleStep) ang_step = d;
      else if (a == RegNearThr) near_thr = d;
    endfunction

    function longint floor_shift(longint v, int s);
      if (v < 0) return -1 - ((-1 - v) >>> s);
      return v >>> s;
    endfunction

    function logic [15:0] q88(longint comp, logic [15:0] rng);
      longint d, mag, q, r;
      if (rng == 0) begin
        r = comp > 0 ? 32767 : (comp < 0 ? -32768 : 0);
      end else begin
        d = longint'(rng) * 4096;
        mag = comp < 0 ? -comp : comp;
        q = (mag + d / 2) / d;
        r = comp < 0 ? -q : q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
      end
      return r[15:0];
    endfunction

    function void note_sample(logic [15:0] rng, logic last);
      logic [15:0] ang;
      logic [31:0] u, tbl;
      bit flip;
      longint x, y, z, dx, dy;
      push_t p;
      if (rng < min_range) begin
        min_range = rng;
        min_idx = idx;
      end
      if (idx < MaxSamples - 1) idx++;
      if (!last) return;
      p = '{1'b0, 16'd0, 16'd0};
      if (min_range < near_thr) begin
        ang = ang_start + ang_step * min_idx[15:0];
        u = {ang, 16'd0};
        flip = 0;
        if (u >= 32'h4000_0000 && u < 32'hC000_0000) begin
          u += 32'h8000_0000;
          flip = 1;
        end
        z = longint'($signed(u));
        x = 652032874; y = 0;
        for (int i = 0; i < CordicSteps; i++) begin
          dx = floor_shift(y, i);
          dy = floor_shift(x, i);
          tbl = atan_turn(i[4:0]);
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(tbl);
          end else begin
            x += dx; y -= dy; z += longint'(tbl);
          end
        end
        if (flip) begin
          x = -x; y = -y;
        end
        p.near = 1'b1;
        p.px = q88(x, min_range);
        p.py = q88(y, min_range);
      end
      pending.push_back(p);
      min_range = 16'hFFFF; min_idx = 0; idx = 0;
    endfunction

    function void check_result(logic near, logic [15:0] px, logic [15:0] py);
      push_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b %h %h", near, px, py);
        return;
      end
      e = pending.pop_front();
      if (e.near !== near || e.px !== px || e.py !== py) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %b %h %h got %b %h %h",
                   e.near, e.px, e.py, near, px, py);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, in_valid_i = 0, out_ready_i = 0, last_sample_i = 0;
  logic [1:0] cfg_index_i = 0;
  logic [15:0] cfg_data_i = 0, range_sample_i = 0;
  logic cfg_ready_o, in_ready_o, out_valid_o, obstacle_seen_o;
  logic signed [15:0] push_x_o, push_y_o;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;
  repulsion_board board = new();

  always #5 clk_i = ~clk_i;

  scan_nearest_obstacle_repulsion DUT (.*);

  // Result side: random stall, check on acceptance
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(obstacle_seen_o, push_x_o, push_y_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  // valid stays high after acceptance; the next send_sample or drain drops it
  task automatic write_cfg(logic [1:0] a, logic [15:0] d);
    cfg_valid_i <= 1; cfg_index_i <= a; cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(a, d);
  endtask

  task automatic send_sample(logic [15:0] rng, logic last);
    cfg_valid_i <= 0;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; range_sample_i <= rng; last_sample_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(rng, last);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    cfg_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Mostly short scans with small ranges so obstacles are common
  task automatic random_scan();
    int len;
    logic [15:0] r;
    len = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: r = 16'($urandom);
        1: r = 16'($urandom_range(3));
        default: r = 16'($urandom_range(2047));
      endcase
      send_sample(r, i == len - 1);
    end
  endtask

  initial begin
    int phase_stall[4] = '{0, 0, 81, 22};
    int phase_idle[4] = '{0, 81, 0, 22};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: extremes, zero range, ties, all ones, zero threshold
    send_sample(16'd0, 1);
    send_sample(16'hFFFF, 0); send_sample(16'hFFFF, 1);
    send_sample(16'd5, 0); send_sample(16'd5, 0); send_sample(16'd7, 1);
    send_sample(16'd1023, 1); send_sample(16'd1024, 1);
    drain();
    write_cfg(RegAngleStart, 16'h8000);
    write_cfg(RegAngleStep, 16'h7FFF);
    write_cfg(RegNearThr, 16'hFFFF);
    write_cfg(RegBeyond, 16'h1234);
    send_sample(16'd9, 0); send_sample(16'd1, 0); send_sample(16'd0, 1);
    send_sample(16'hFFFE, 1); send_sample(16'hAAAA, 0); send_sample(16'h5555, 1);
    drain();
    write_cfg(RegNearThr, 16'd0);
    send_sample(16'd0, 1);
    drain();
    // Overlong scan: index saturates
    write_cfg(RegNearThr, 16'd2000);
    write_cfg(RegAngleStep, 16'd1);
    for (int i = 0; i < 2052; i++) send_sample(i < 2050 ? 16'd1500 : 16'd100, i == 2051);
    drain();
    // Random phases with different settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = phase_idle[ph];
      recv_stall = phase_stall[ph];
      write_cfg(RegAngleStart, 16'($urandom));
      write_cfg(RegAngleStep, ph == 0 ? 16'h8000 : 16'($urandom));
      write_cfg(RegNearThr, ph == 1 ? 16'hFFFF : 16'($urandom_range(4096)));
      for (int n = 0; n < 8; n++) random_scan();
      drain();
    end
    recv_stall = 0;
    drain();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/snor_pkg.sv
rtl/snor_front.sv
rtl/snor_back.sv
rtl/scan_nearest_obstacle_repulsion.sv
rtl/snor_checker.sv
test/scan_nearest_obstacle_repulsion_tb.sv
